>>> rtl/tsp_pkg.sv
package tsp_pkg;

    // Configuration and field widths
    localparam int MAX_TERMS = 16;
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 5;
    localparam int TE_W      = CNT_W + 1;
    localparam int X_W       = 21;
    localparam int OUT_W     = 48;

    // |x| reaches 2^(X_W-1), so the magnitude keeps all X_W bits
    localparam int MAG_W  = X_W;
    localparam int X2_W   = 2 * (X_W - 1) + 1 - FRAC_BITS;

    // Term magnitudes peak near 2^36 at |x| = 16; partial sums stay below 2^39
    localparam int TERM_W = 38;
    localparam int HALF_W = TERM_W / 2;
    localparam int HI_W   = TERM_W - HALF_W;
    localparam int P_W    = TERM_W + X2_W;
    localparam int SUM_W  = 42;

    // Constant divider: numerator taken CHUNK_W bits per step
    localparam int CHUNK_W = 16;
    localparam int N_CHUNK = (P_W + 1 - FRAC_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int A_W     = N_CHUNK * CHUNK_W;
    localparam int D_MAX   = (MAX_TERMS > 1) ? (2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1) : 6;
    localparam int D_W     = $clog2(D_MAX + 1);
    localparam int Y_W     = D_W + CHUNK_W;
    localparam int M_W     = Y_W - 2;

    typedef struct packed {
        logic                    valid;
        logic                    neg;
        logic [X2_W-1:0]         x2;
        logic signed [SUM_W-1:0] sum;
    } ctx_t;

endpackage

>>> rtl/tsp_divstep.sv
module tsp_divstep (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic [tsp_pkg::D_W-1:0] div_d,
    input  logic [tsp_pkg::M_W-1:0] recip,
    input  tsp_pkg::ctx_t           ctx_in,
    input  logic [tsp_pkg::D_W-1:0] rem_in,
    input  logic [tsp_pkg::A_W-1:0] num_in,
    input  logic [tsp_pkg::A_W-1:0] quo_in,
    output tsp_pkg::ctx_t           ctx_out,
    output logic [tsp_pkg::D_W-1:0] rem_out,
    output logic [tsp_pkg::A_W-1:0] num_out,
    output logic [tsp_pkg::A_W-1:0] quo_out
);
    import tsp_pkg::*;

    localparam int PR_W = Y_W + M_W;

    ctx_t              ctx1_reg;
    logic [Y_W-1:0]    y_reg;
    logic [PR_W-1:0]   prod_reg;
    logic [A_W-1:0]    num1_reg;
    logic [A_W-1:0]    quo1_reg;

    ctx_t              ctx2_reg;
    logic [D_W-1:0]    rem2_reg;
    logic [A_W-1:0]    num2_reg;
    logic [A_W-1:0]    quo2_reg;

    logic [Y_W-1:0]     y_next;
    logic [CHUNK_W-1:0] q_est;
    logic [Y_W-1:0]     qd;
    logic [Y_W-1:0]     rem_full;
    logic               fix;
    logic [Y_W-1:0]     rem_fix;
    logic [CHUNK_W-1:0] q_digit;

    // partial remainder joined with the next chunk, always below div_d * 2^CHUNK_W
    assign y_next = {rem_in, num_in[A_W-1 -: CHUNK_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx1_reg <= '0;
            ctx2_reg <= '0;
        end
        else if (adv)
        begin
            ctx1_reg <= ctx_in;
            ctx2_reg <= ctx1_reg;
        end
    end

    // digit estimate: floor reciprocal, at most one short
    always_comb
    begin
        q_est    = prod_reg[Y_W +: CHUNK_W];
        qd       = Y_W'(q_est) * Y_W'(div_d);
        rem_full = y_reg - qd;
        fix      = (rem_full >= Y_W'(div_d));
        rem_fix  = fix ? (rem_full - Y_W'(div_d)) : rem_full;
        q_digit  = q_est + CHUNK_W'(fix);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg    <= y_next;
            prod_reg <= PR_W'(y_next) * PR_W'(recip);
            num1_reg <= num_in << CHUNK_W;
            quo1_reg <= quo_in;
            rem2_reg <= rem_fix[D_W-1:0];
            num2_reg <= num1_reg;
            quo2_reg <= {quo1_reg[A_W-CHUNK_W-1:0], q_digit};
        end
    end

    assign ctx_out = ctx2_reg;
    assign rem_out = rem2_reg;
    assign num_out = num2_reg;
    assign quo_out = quo2_reg;

    a_one_correction: assert property (@(posedge clk) disable iff (!rst_n)
        ctx1_reg.valid |-> (rem_full < {1'b0, div_d, 1'b0}))
        else $error("digit estimate off by more than one");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        ctx2_reg.valid |-> (rem2_reg < div_d))
        else $error("partial remainder not reduced");

endmodule

>>> rtl/tsp_term.sv
module tsp_term (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic [tsp_pkg::D_W-1:0]    div_d,
    input  logic [tsp_pkg::M_W-1:0]    recip,
    input  logic                       add_en,
    input  logic                       odd_term,
    input  tsp_pkg::ctx_t              ctx_in,
    input  logic [tsp_pkg::TERM_W-1:0] tm_in,
    output tsp_pkg::ctx_t              ctx_out,
    output logic [tsp_pkg::TERM_W-1:0] tm_out
);
    import tsp_pkg::*;

    localparam int LO_P_W = HALF_W + X2_W;
    localparam int HI_P_W = HI_W + X2_W;

    ctx_t               ctx1_reg;
    ctx_t               ctx2_reg;
    ctx_t               ctx1_next;
    logic [LO_P_W-1:0]  pp_lo_reg;
    logic [HI_P_W-1:0]  pp_hi_reg;
    logic [A_W-1:0]     a_reg;
    logic [P_W:0]       a_full;

    logic                    term_neg;
    logic signed [SUM_W-1:0] tm_ext;

    ctx_t           ctx_c [N_CHUNK+1];
    logic [D_W-1:0] rem_c [N_CHUNK+1];
    logic [A_W-1:0] num_c [N_CHUNK+1];
    logic [A_W-1:0] quo_c [N_CHUNK+1];

    // fold the previous term into the running sum
    always_comb
    begin
        term_neg  = ctx_in.neg ^ odd_term;
        tm_ext    = $signed({{(SUM_W-TERM_W){1'b0}}, tm_in});
        ctx1_next = ctx_in;
        if (add_en)
        begin
            ctx1_next.sum = term_neg ? (ctx_in.sum - tm_ext) : (ctx_in.sum + tm_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx1_reg <= '0;
            ctx2_reg <= '0;
        end
        else if (adv)
        begin
            ctx1_reg <= ctx1_next;
            ctx2_reg <= ctx1_reg;
        end
    end

    // half-up rounding folded in before the divide by d * 2^FRAC_BITS
    assign a_full = (P_W+1)'({pp_hi_reg, {HALF_W{1'b0}}}) + (P_W+1)'(pp_lo_reg)
                  + ((P_W+1)'(div_d) << (FRAC_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_lo_reg <= LO_P_W'(tm_in[HALF_W-1:0]) * LO_P_W'(ctx_in.x2);
            pp_hi_reg <= HI_P_W'(tm_in[TERM_W-1:HALF_W]) * HI_P_W'(ctx_in.x2);
            a_reg     <= A_W'(a_full >> FRAC_BITS);
        end
    end

    assign ctx_c[0] = ctx2_reg;
    assign rem_c[0] = '0;
    assign num_c[0] = a_reg;
    assign quo_c[0] = '0;

    for (genvar k = 0; k < N_CHUNK; k++)
    begin : g_div
        tsp_divstep u_divstep (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .div_d   (div_d),
            .recip   (recip),
            .ctx_in  (ctx_c[k]),
            .rem_in  (rem_c[k]),
            .num_in  (num_c[k]),
            .quo_in  (quo_c[k]),
            .ctx_out (ctx_c[k+1]),
            .rem_out (rem_c[k+1]),
            .num_out (num_c[k+1]),
            .quo_out (quo_c[k+1])
        );
    end

    assign ctx_out = ctx_c[N_CHUNK];
    assign tm_out  = quo_c[N_CHUNK][TERM_W-1:0];

    a_term_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_c[N_CHUNK].valid |-> (quo_c[N_CHUNK][A_W-1:TERM_W] == '0))
        else $error("series term wider than term path");

endmodule

>>> rtl/taylor_sine_polynomial.sv
// Truncated Maclaurin sine evaluator, one result beat per argument beat.
// Input channel: x_value (signed, 16 fraction bits) with in_valid / in_ready.
// Output channel: series_sum (signed Q32.16) with out_valid / out_ready.
// Config: cfg_we writes cfg_wdata into the term count; counts
//   above MAX_TERMS act as MAX_TERMS, zero gives a sum of zero. Write only
//   while no beat is in flight.
// Structure: a two-stage front end forms |x| and x^2, then one unit per
//   series term j: split 19x25 multiply of the previous term by x^2, a
//   rounding add, and a divide by (2j)(2j+1) done 16 bits at a time by a
//   reciprocal multiply plus one correction (two stages per chunk).
// Throughput: one beat per cycle while back-pressure does not hold the pipe.
// Back-pressure: the whole pipe holds while the output register is full and
//   not taken, unless the last stage is empty; in_ready then drops. Nothing
//   in flight is lost or repeated.
// Reset: term count clears to zero, all stage valids and out_valid clear.
module taylor_sine_polynomial (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tsp_pkg::CNT_W-1:0]        cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [tsp_pkg::X_W-1:0]   x_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [tsp_pkg::OUT_W-1:0] series_sum
);
    import tsp_pkg::*;

    localparam int LAST = MAX_TERMS - 1;
    localparam logic ODD_LAST = 1'(LAST % 2);

    logic [CNT_W-1:0]  term_count_reg;
    logic [TE_W-1:0]   terms_eff;

    logic              adv;
    logic              out_load;

    // front end
    logic              f1_valid_reg;
    logic              f1_neg_reg;
    logic [MAG_W-1:0]  f1_mag_reg;
    logic [MAG_W-1:0]  mag_next;
    logic [X_W-1:0]    x_bits;
    logic [2*MAG_W-1:0] sq_round;

    ctx_t              f2_ctx_reg;
    logic [TERM_W-1:0] f2_tm_reg;

    // per-term chain, index 0 is the front end output
    ctx_t              stage_ctx [MAX_TERMS];
    logic [TERM_W-1:0] stage_tm  [MAX_TERMS];

    // last term and output register
    logic                    last_neg;
    logic                    add_last;
    logic signed [SUM_W-1:0] last_ext;
    logic signed [SUM_W-1:0] sum_fin;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            term_count_reg <= cfg_wdata;
        end
    end

    assign terms_eff = ({1'b0, term_count_reg} > TE_W'(MAX_TERMS)) ? TE_W'(MAX_TERMS)
                                                                  : {1'b0, term_count_reg};

    // output register frees when empty or taken; an empty last stage lets the
    // pipe move even while a result waits
    assign out_load = !out_valid_reg || out_ready;
    assign adv      = out_load || !stage_ctx[LAST].valid;
    assign in_ready = adv;

    // stage F1: sign and magnitude; -2^20 wraps to the unsigned 2^20
    assign x_bits   = x_value;
    assign mag_next = x_bits[X_W-1] ? (~x_bits + MAG_W'(1)) : x_bits;

    // stage F2: x^2 rounded half up
    assign sq_round = (2*MAG_W)'(f1_mag_reg) * (2*MAG_W)'(f1_mag_reg)
                    + ((2*MAG_W)'(1) << (FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_ctx_reg   <= '0;
        end
        else if (adv)
        begin
            f1_valid_reg     <= in_valid;
            f2_ctx_reg.valid <= f1_valid_reg;
            f2_ctx_reg.neg   <= f1_neg_reg;
            f2_ctx_reg.x2    <= X2_W'(sq_round >> FRAC_BITS);
            f2_ctx_reg.sum   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_neg_reg <= x_bits[X_W-1];
            f1_mag_reg <= mag_next;
            f2_tm_reg  <= TERM_W'(f1_mag_reg);
        end
    end

    assign stage_ctx[0] = f2_ctx_reg;
    assign stage_tm[0]  = f2_tm_reg;

    // unit j adds term j-1 to the sum and forms term j
    for (genvar j = 1; j < MAX_TERMS; j++)
    begin : g_term
        localparam int DIV_D = (2 * j) * (2 * j + 1);
        localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << Y_W) / DIV_D);
        localparam logic ODD_PREV = 1'((j - 1) % 2);

        tsp_term u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .div_d    (D_W'(DIV_D)),
            .recip    (RECIP),
            .add_en   (TE_W'(j - 1) < terms_eff),
            .odd_term (ODD_PREV),
            .ctx_in   (stage_ctx[j-1]),
            .tm_in    (stage_tm[j-1]),
            .ctx_out  (stage_ctx[j]),
            .tm_out   (stage_tm[j])
        );
    end

    // final term folded in on the way into the output register
    always_comb
    begin
        last_neg = stage_ctx[LAST].neg ^ ODD_LAST;
        add_last = (TE_W'(LAST) < terms_eff);
        last_ext = $signed({{(SUM_W-TERM_W){1'b0}}, stage_tm[LAST]});
        sum_fin  = stage_ctx[LAST].sum;
        if (add_last)
        begin
            sum_fin = last_neg ? (stage_ctx[LAST].sum - last_ext)
                               : (stage_ctx[LAST].sum + last_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= stage_ctx[LAST].valid;
        end
    end

    // partial sums stay well inside SUM_W, so a sign extension is exact
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sum_reg <= {{(OUT_W-SUM_W){sum_fin[SUM_W-1]}}, sum_fin};
        end
    end

    assign out_valid  = out_valid_reg;
    assign series_sum = sum_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input held off with an empty output register");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && stage_ctx[LAST].valid) |-> !in_ready)
        else $error("pipe advanced into a stalled output");

endmodule
